FILE: sv/obbt_pkg.sv
// Shared widths, register codes and the configuration struct of the box overlap test.
package obbt_pkg;

	// Field formats
	localparam int CW = 20;              // coordinate width, Q10.10
	localparam int AW = 16;              // axis part width, Q1.14
	localparam int CF = CW / 2;          // coordinate fraction bits
	localparam int AF = AW - 2;          // axis fraction bits
	localparam int TF = 14;              // tolerance fraction bits
	localparam int RW = CW + 2;          // bounding radius width

	// Datapath widths
	localparam int DW   = CW + 1;        // center difference
	localparam int PDW  = DW + AW;       // difference times axis part
	localparam int TSW  = PDW + 2;       // sum of three such products
	localparam int PRW  = 2 * AW;        // axis part product
	localparam int RSW  = PRW + 2;       // dot product of two axes
	localparam int TW   = TSW + 1 - AF;  // rounded projected distance
	localparam int RRW  = RSW + 1 - AF;  // rounded rotation term
	localparam int ABW  = RRW + 1;       // absolute rotation term plus epsilon
	localparam int RRSW = RW + 2;        // radius sum plus epsilon
	localparam int SQW  = 2 * DW;        // squared difference part
	localparam int L2W  = SQW + 2;       // squared distance
	localparam int RR2W = 2 * RRSW;      // squared radius sum
	localparam int PAW  = CW + ABW;      // half-extent times abs rotation
	localparam int PTW  = TW + RRW;      // distance times rotation
	localparam int CMPW = PTW + 3;       // separating test compare width

	// Stream packing
	localparam int OFF_CEN  = 0;
	localparam int OFF_AX0  = 3 * CW;
	localparam int OFF_AX1  = 3 * CW + 3 * AW;
	localparam int OFF_AX2  = 3 * CW + 6 * AW;
	localparam int OFF_HALF = 3 * CW + 9 * AW;
	localparam int OFF_RAD  = 6 * CW + 9 * AW;
	localparam int IN_BITS  = 6 * CW + 9 * AW + RW;
	localparam int IN_TDW   = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_TDW  = 8;

	// Configuration port
	localparam int CFG_DW = 3 * CW;
	localparam int CFG_IW = 3;

	typedef enum logic [CFG_IW-1:0] {
		REG_A_CENTER = 3'd0,
		REG_A_AXIS0  = 3'd1,
		REG_A_AXIS1  = 3'd2,
		REG_A_AXIS2  = 3'd3,
		REG_A_HALF   = 3'd4,
		REG_A_RADIUS = 3'd5,
		REG_TOL      = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [3*CW-1:0]         a_center;
		logic [2:0][3*AW-1:0]    a_axis;
		logic [3*CW-1:0]         a_half;
		logic [RW-1:0]           a_radius;
		logic [TF-1:0]           tol;
	} cfg_t;

endpackage

FILE: sv/obbt_cfg.sv
// Configuration register file holding reference box A and the tolerance.
module obbt_cfg
	import obbt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	// register write decode, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_A_CENTER: cfg_q.a_center <= cfg_data[3*CW-1:0];
				REG_A_AXIS0:  cfg_q.a_axis[0] <= cfg_data[3*AW-1:0];
				REG_A_AXIS1:  cfg_q.a_axis[1] <= cfg_data[3*AW-1:0];
				REG_A_AXIS2:  cfg_q.a_axis[2] <= cfg_data[3*AW-1:0];
				REG_A_HALF:   cfg_q.a_half <= cfg_data[3*CW-1:0];
				REG_A_RADIUS: cfg_q.a_radius <= cfg_data[RW-1:0];
				REG_TOL:      cfg_q.tol <= cfg_data[TF-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: sv/obb_overlap_test_core.sv
// Top level: pipelined oriented box overlap and point containment test.
//
// Usage:
//   Reference box A and the tolerance are written through the cfg_we /
//   cfg_index / cfg_data port while no item is in flight. Each transfer on the
//   slave stream carries box B (or a query point in s_tdata's center field)
//   and the mode in s_tuser; mode 0 tests box overlap, mode 1 tests the point
//   against box A. Every input gives exactly one transfer on the master
//   stream, with hit in m_tdata bit 0.
// Timing:
//   Seven register stages: difference, products, sums and sphere square,
//   rounding, rotation products, axis compares, result. One item per
//   cycle is accepted while the output is not stalled; the multiplier
//   stages set the depth, not the rate.
// Reset:
//   arst_n clears all valid bits and the configuration to zero.
// Stalls:
//   When m_tready is low with a result waiting, the whole pipeline holds
//   and s_tready drops; nothing is lost or repeated. Empty stages are not
//   filled while the output waits.
module obb_overlap_test_core
	import obbt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CFG_IW-1:0]  cfg_index,
	input  logic [CFG_DW-1:0]  cfg_data,
	input  logic               s_tvalid,
	output logic               s_tready,
	// b_center, b_axis_zero, b_axis_one, b_axis_two, b_half_sizes, b_bound_radius
	input  logic [IN_TDW-1:0]  s_tdata,
	// mode
	input  logic               s_tuser,
	output logic               m_tvalid,
	input  logic               m_tready,
	// hit
	output logic [OUT_TDW-1:0] m_tdata
);

	cfg_t cfg;

	obbt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// unpacked reference box
	logic signed [CW-1:0] a_cen [3];
	logic signed [AW-1:0] a_ax  [3][3];
	logic [CW-1:0]        a_h   [3];
	logic [RRSW-1:0]      eps_c;
	logic [ABW-1:0]       eps_a;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			a_cen[k] = $signed(cfg.a_center[k*CW +: CW]);
			a_h[k]   = cfg.a_half[k*CW +: CW];
			for (int i = 0; i < 3; i++) begin
				a_ax[i][k] = $signed(cfg.a_axis[i][k*AW +: AW]);
			end
		end
		eps_c = RRSW'(cfg.tol >> (TF - CF));
		if (AF >= TF) begin
			eps_a = ABW'(ABW'(cfg.tol) << (AF >= TF ? AF - TF : 0));
		end else begin
			eps_a = ABW'(cfg.tol >> (AF >= TF ? 0 : TF - AF));
		end
	end

	// pipeline control
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en;

	assign en       = !v_s7 || m_tready;
	assign s_tready = en;
	assign m_tvalid = v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <= '0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// stage payloads
	logic                  mode_s1, mode_s2, mode_s3, mode_s4, mode_s5, mode_s6;
	logic signed [DW-1:0]  d_s1 [3];
	logic signed [AW-1:0]  bax_s1 [3][3];
	logic [CW-1:0]         bh_s1 [3], bh_s2 [3], bh_s3 [3], bh_s4 [3], bh_s5 [3];
	logic [RW-1:0]         br_s1;

	logic signed [PDW-1:0] pd_s2 [3][3];
	logic signed [PRW-1:0] pr_s2 [3][3][3];
	logic [SQW-1:0]        dsq_s2 [3];
	logic [RRSW-1:0]       rr_s2;

	logic signed [TSW-1:0] st_s3 [3];
	logic signed [RSW-1:0] sr_s3 [3][3];
	logic [L2W-1:0]        len2_s3;
	logic [RR2W-1:0]       rr2_s3;

	logic signed [TW-1:0]  t_s4 [3];
	logic signed [RRW-1:0] r_s4 [3][3];
	logic [ABW-1:0]        ab_s4 [3][3];
	logic                  sph_s4, sph_s5, sph_s6;
	logic                  pt_s4, pt_s5, pt_s6;

	logic [PAW-1:0]        pa_s5 [3][3][3];
	logic [PAW-1:0]        pb_s5 [3][3][3];
	logic signed [PTW-1:0] ptr_s5 [3][3][3];
	logic [TW-1:0]         tabs_s5 [3];

	logic [14:0]           sep_s6;
	logic                  hit_s7;

	// stage 4 rounding and stage 6 compares
	logic signed [TW-1:0]  t_c [3];
	logic signed [RRW-1:0] r_c [3][3];
	logic [ABW-1:0]        ab_c [3][3];
	logic                  pt_c;
	logic [14:0]           sep_c;

	always_comb begin
		logic [TSW:0]   tm;
		logic [TW-1:0]  tr;
		logic [RSW:0]   rm;
		logic [RRW-1:0] rq;
		logic [RRW-1:0] rabs;
		pt_c = 1'b1;
		for (int i = 0; i < 3; i++) begin
			tm = {1'b0, TSW'(st_s3[i][TSW-1] ? -st_s3[i] : st_s3[i])}
				+ (TSW+1)'(1 << (AF - 1));
			tr = TW'(tm >> AF);
			t_c[i] = st_s3[i][TSW-1] ? -$signed(tr) : $signed(tr);
			if (tm - (TSW+1)'(1 << (AF - 1)) > ((TSW+1)'(a_h[i]) << AF)) begin
				pt_c = 1'b0;
			end
			for (int j = 0; j < 3; j++) begin
				rm = {1'b0, RSW'(sr_s3[i][j][RSW-1] ? -sr_s3[i][j] : sr_s3[i][j])}
					+ (RSW+1)'(1 << (AF - 1));
				rq = RRW'(rm >> AF);
				r_c[i][j] = sr_s3[i][j][RSW-1] ? -$signed(rq) : $signed(rq);
				rabs = r_c[i][j][RRW-1] ? RRW'(-r_c[i][j]) : RRW'(r_c[i][j]);
				ab_c[i][j] = ABW'(rabs) + eps_a;
			end
		end
	end

	always_comb begin
		logic [CMPW-1:0]        lhs, ra, rb;
		logic signed [CMPW-1:0] sl;
		int i1, i2, j1, j2;
		// face axes of A
		for (int i = 0; i < 3; i++) begin
			lhs = CMPW'(tabs_s5[i]) << AF;
			ra  = CMPW'(a_h[i]) << AF;
			rb  = CMPW'(pb_s5[i][0][0]) + CMPW'(pb_s5[i][1][1]) + CMPW'(pb_s5[i][2][2]);
			sep_c[i] = lhs > ra + rb;
		end
		// face axes of B
		for (int j = 0; j < 3; j++) begin
			sl  = CMPW'(ptr_s5[0][0][j]) + CMPW'(ptr_s5[1][1][j]) + CMPW'(ptr_s5[2][2][j]);
			lhs = sl[CMPW-1] ? CMPW'(-sl) : CMPW'(sl);
			ra  = CMPW'(pa_s5[0][0][j]) + CMPW'(pa_s5[1][1][j]) + CMPW'(pa_s5[2][2][j]);
			rb  = CMPW'(bh_s5[j]) << AF;
			sep_c[3 + j] = lhs > ra + rb;
		end
		// edge cross products
		for (int i = 0; i < 3; i++) begin
			i1 = (i == 2) ? 0 : i + 1;
			i2 = (i == 0) ? 2 : i - 1;
			for (int j = 0; j < 3; j++) begin
				j1 = (j == 2) ? 0 : j + 1;
				j2 = (j == 0) ? 2 : j - 1;
				sl  = CMPW'(ptr_s5[i2][i1][j]) - CMPW'(ptr_s5[i1][i2][j]);
				lhs = sl[CMPW-1] ? CMPW'(-sl) : CMPW'(sl);
				ra  = CMPW'(pa_s5[i1][i2][j]) + CMPW'(pa_s5[i2][i1][j]);
				rb  = CMPW'(pb_s5[i][j1][j2]) + CMPW'(pb_s5[i][j2][j1]);
				sep_c[6 + 3*i + j] = lhs > ra + rb;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: center difference, unpack B
			mode_s1 <= s_tuser;
			br_s1   <= s_tdata[OFF_RAD +: RW];
			for (int k = 0; k < 3; k++) begin
				d_s1[k]  <= DW'($signed(s_tdata[OFF_CEN + k*CW +: CW])) - DW'(a_cen[k]);
				bh_s1[k] <= s_tdata[OFF_HALF + k*CW +: CW];
				bax_s1[0][k] <= $signed(s_tdata[OFF_AX0 + k*AW +: AW]);
				bax_s1[1][k] <= $signed(s_tdata[OFF_AX1 + k*AW +: AW]);
				bax_s1[2][k] <= $signed(s_tdata[OFF_AX2 + k*AW +: AW]);
			end

			// stage 2: products, radius sum plus epsilon
			mode_s2 <= mode_s1;
			bh_s2   <= bh_s1;
			rr_s2   <= RRSW'(cfg.a_radius) + RRSW'(br_s1) + eps_c;
			for (int k = 0; k < 3; k++) begin
				dsq_s2[k] <= d_s1[k] * d_s1[k];
				for (int i = 0; i < 3; i++) begin
					pd_s2[i][k] <= d_s1[k] * a_ax[i][k];
					for (int j = 0; j < 3; j++) begin
						pr_s2[i][j][k] <= a_ax[i][k] * bax_s1[j][k];
					end
				end
			end

			// stage 3: sums, squared radius
			mode_s3 <= mode_s2;
			bh_s3   <= bh_s2;
			len2_s3 <= L2W'(dsq_s2[0]) + L2W'(dsq_s2[1]) + L2W'(dsq_s2[2]);
			rr2_s3  <= RR2W'(rr_s2) * RR2W'(rr_s2);
			for (int i = 0; i < 3; i++) begin
				st_s3[i] <= TSW'(pd_s2[i][0]) + TSW'(pd_s2[i][1]) + TSW'(pd_s2[i][2]);
				for (int j = 0; j < 3; j++) begin
					sr_s3[i][j] <= RSW'(pr_s2[i][j][0]) + RSW'(pr_s2[i][j][1])
						+ RSW'(pr_s2[i][j][2]);
				end
			end

			// stage 4: rounding, sphere and point decisions
			mode_s4 <= mode_s3;
			bh_s4   <= bh_s3;
			t_s4    <= t_c;
			r_s4    <= r_c;
			ab_s4   <= ab_c;
			sph_s4  <= RR2W'(len2_s3) > rr2_s3;
			pt_s4   <= pt_c;

			// stage 5: projected radius and distance products
			mode_s5 <= mode_s4;
			bh_s5   <= bh_s4;
			sph_s5  <= sph_s4;
			pt_s5   <= pt_s4;
			for (int p = 0; p < 3; p++) begin
				tabs_s5[p] <= t_s4[p][TW-1] ? TW'(-t_s4[p]) : TW'(t_s4[p]);
				for (int q = 0; q < 3; q++) begin
					for (int j = 0; j < 3; j++) begin
						pa_s5[p][q][j]  <= PAW'(a_h[p]) * PAW'(ab_s4[q][j]);
						pb_s5[j][p][q]  <= PAW'(bh_s4[p]) * PAW'(ab_s4[j][q]);
						ptr_s5[p][q][j] <= t_s4[p] * r_s4[q][j];
					end
				end
			end

			// stage 6: fifteen axis tests
			mode_s6 <= mode_s5;
			sph_s6  <= sph_s5;
			pt_s6   <= pt_s5;
			sep_s6  <= sep_c;

			// stage 7: result
			hit_s7 <= mode_s6 ? pt_s6 : (!sph_s6 && !(|sep_s6));
		end
	end

	assign m_tdata = {(OUT_TDW-1)'(0), hit_s7};

	// a valid stage 3 moves on to stage 4 whenever the pipeline advances
	a_valid_moves: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && en |=> v_s4)
		else $error("valid bit lost between stages 3 and 4");

	// a blocked output freezes the input side
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input accepted while output is blocked");

	// a sphere reject in box mode always yields a miss
	a_sphere_miss: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && en && !mode_s6 && sph_s6 |=> !hit_s7)
		else $error("sphere reject did not clear hit");

endmodule

FILE: sim/obb_overlap_test_core_test.sv
// Testbench for the oriented box overlap and point containment core.
`timescale 1ns / 1ps

module obb_overlap_test_core_test;
	import obbt_pkg::*;

	localparam int LATENCY = 7;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [CFG_IW-1:0]  cfg_index = '0;
	logic [CFG_DW-1:0]  cfg_data = '0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [IN_TDW-1:0]  s_tdata = '0;
	logic               s_tuser = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [OUT_TDW-1:0] m_tdata;

	obb_overlap_test_core i_dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// one query: mode plus packed tdata
	typedef struct {
		logic              mode;
		logic [IN_TDW-1:0] data;
		int                known;   // -1 means use the predictor
	} query_t;

	// shadow of box A and the tolerance
	logic [3*CW-1:0] sh_center, sh_half;
	logic [3*AW-1:0] sh_axis [3];
	logic [RW-1:0]   sh_radius;
	logic [TF-1:0]   sh_tol;

	bit   hit_queue [$];
	int   mismatches = 0;
	bit   hold_off = 1'b0;

	function automatic longint sfield(logic [63:0] p, int k, int w);
		logic [63:0] v;
		v = (p >> (k * w)) & ((64'd1 << w) - 1);
		if (v[w-1]) return longint'(v) - (longint'(1) << w);
		return longint'(v);
	endfunction

	function automatic longint ufield(logic [63:0] p, int k, int w);
		return longint'((p >> (k * w)) & ((64'd1 << w) - 1));
	endfunction

	function automatic longint absv(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint round_af(longint v);
		longint r;
		r = (absv(v) + (longint'(1) << (AF - 1))) >>> AF;
		return v < 0 ? -r : r;
	endfunction

	// expected hit for one query against the shadow registers
	function automatic bit predict_hit(query_t q);
		longint d[3], aa[3][3], ba[3][3], rot[3][3], ab[3][3], t[3], ah[3], bh[3];
		longint one, eps_c, eps_a, len2, rr, ra, rb, lhs, s;
		int i1, i2, j1, j2;
		one = longint'(1) << AF;
		for (int k = 0; k < 3; k++) begin
			d[k] = sfield(q.data[OFF_CEN +: 3*CW], k, CW) - sfield(sh_center, k, CW);
			ah[k] = ufield(sh_half, k, CW);
			bh[k] = ufield(q.data[OFF_HALF +: 3*CW], k, CW);
			for (int m = 0; m < 3; m++) begin
				aa[k][m] = sfield(sh_axis[k], m, AW);
				ba[k][m] = sfield(q.data[OFF_AX0 + k*3*AW +: 3*AW], m, AW);
			end
		end
		if (q.mode) begin
			for (int i = 0; i < 3; i++) begin
				s = d[0]*aa[i][0] + d[1]*aa[i][1] + d[2]*aa[i][2];
				if (absv(s) > ah[i] * one) return 1'b0;
			end
			return 1'b1;
		end
		eps_c = longint'(sh_tol) >>> (TF - CF);
		eps_a = longint'(sh_tol) << (AF - TF);
		len2 = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
		rr = longint'(sh_radius) + longint'(q.data[OFF_RAD +: RW]) + eps_c;
		if (len2 > rr * rr) return 1'b0;
		for (int i = 0; i < 3; i++) begin
			t[i] = round_af(d[0]*aa[i][0] + d[1]*aa[i][1] + d[2]*aa[i][2]);
			for (int j = 0; j < 3; j++) begin
				rot[i][j] = round_af(aa[i][0]*ba[j][0] + aa[i][1]*ba[j][1]
					+ aa[i][2]*ba[j][2]);
				ab[i][j] = absv(rot[i][j]) + eps_a;
			end
		end
		// face axes of A, then of B
		for (int i = 0; i < 3; i++) begin
			rb = bh[0]*ab[i][0] + bh[1]*ab[i][1] + bh[2]*ab[i][2];
			if (absv(t[i]) * one > ah[i] * one + rb) return 1'b0;
		end
		for (int j = 0; j < 3; j++) begin
			ra = ah[0]*ab[0][j] + ah[1]*ab[1][j] + ah[2]*ab[2][j];
			lhs = absv(t[0]*rot[0][j] + t[1]*rot[1][j] + t[2]*rot[2][j]);
			if (lhs > ra + bh[j] * one) return 1'b0;
		end
		// edge cross products
		for (int i = 0; i < 3; i++) begin
			i1 = (i + 1) % 3;
			i2 = (i + 2) % 3;
			for (int j = 0; j < 3; j++) begin
				j1 = (j + 1) % 3;
				j2 = (j + 2) % 3;
				ra = ah[i1]*ab[i2][j] + ah[i2]*ab[i1][j];
				rb = bh[j1]*ab[i][j2] + bh[j2]*ab[i][j1];
				lhs = absv(t[i2]*rot[i1][j] - t[i1]*rot[i2][j]);
				if (lhs > ra + rb) return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	function automatic logic [3*CW-1:0] pack_c(int x, int y, int z);
		return {CW'(z), CW'(y), CW'(x)};
	endfunction

	function automatic logic [3*AW-1:0] pack_a(int x, int y, int z);
		return {AW'(z), AW'(y), AW'(x)};
	endfunction

	function automatic logic [IN_TDW-1:0] build_box(logic [3*CW-1:0] cen,
		logic [3*AW-1:0] a0, logic [3*AW-1:0] a1, logic [3*AW-1:0] a2,
		logic [3*CW-1:0] half, logic [RW-1:0] rad);
		logic [IN_TDW-1:0] v;
		v = '0;
		v[OFF_CEN +: 3*CW] = cen;
		v[OFF_AX0 +: 3*AW] = a0;
		v[OFF_AX1 +: 3*AW] = a1;
		v[OFF_AX2 +: 3*AW] = a2;
		v[OFF_HALF +: 3*CW] = half;
		v[OFF_RAD +: RW] = rad;
		return v;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// coordinate near zero, mostly small so boxes meet often
	function automatic int near_coord(int span);
		return $urandom_range(2 * span) - span;
	endfunction

	// write one register between phases, keep the shadow in step
	task automatic write_reg(reg_idx_t idx, logic [CFG_DW-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_A_CENTER: sh_center = val[3*CW-1:0];
			REG_A_AXIS0:  sh_axis[0] = val[3*AW-1:0];
			REG_A_AXIS1:  sh_axis[1] = val[3*AW-1:0];
			REG_A_AXIS2:  sh_axis[2] = val[3*AW-1:0];
			REG_A_HALF:   sh_half = val[3*CW-1:0];
			REG_A_RADIUS: sh_radius = val[RW-1:0];
			REG_TOL:      sh_tol = val[TF-1:0];
			default: ;
		endcase
	endtask

	task automatic write_box_a(logic [3*CW-1:0] cen, logic [3*AW-1:0] a0,
		logic [3*AW-1:0] a1, logic [3*AW-1:0] a2, logic [3*CW-1:0] half,
		logic [RW-1:0] rad, logic [TF-1:0] tol);
		write_reg(REG_A_CENTER, CFG_DW'(cen));
		write_reg(REG_A_AXIS0, CFG_DW'(a0));
		write_reg(REG_A_AXIS1, CFG_DW'(a1));
		write_reg(REG_A_AXIS2, CFG_DW'(a2));
		write_reg(REG_A_HALF, CFG_DW'(half));
		write_reg(REG_A_RADIUS, CFG_DW'(rad));
		write_reg(REG_TOL, CFG_DW'(tol));
	endtask

	// stop offering and wait until every result is back
	task automatic drain();
		s_tvalid <= 1'b0;
		while (hit_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// send one query, with an optional gap before it
	task automatic send(query_t q, bit gaps);
		int gap;
		gap = 0;
		if (gaps && $urandom_range(3) == 0)
			gap = ($urandom_range(15) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= q.data;
		s_tuser <= q.mode;
		hit_queue.push_back(q.known >= 0 ? bit'(q.known) : predict_hit(q));
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	function automatic query_t random_query();
		query_t q;
		int span;
		q.known = -1;
		q.mode = $urandom_range(3) == 0;
		if ($urandom_range(9) == 0) begin
			// full random bit patterns
			q.data = IN_TDW'({rand64(), rand64(), rand64(), rand64(), rand64()});
			q.data[IN_TDW-1:IN_BITS] = '0;
			return q;
		end
		span = ($urandom_range(3) == 0) ? 20000 : 3000;
		q.data = build_box(
			pack_c(near_coord(span), near_coord(span), near_coord(span)),
			pack_a(near_coord(16384), near_coord(16384), near_coord(16384)),
			pack_a(near_coord(16384), near_coord(16384), near_coord(16384)),
			pack_a(near_coord(16384), near_coord(16384), near_coord(16384)),
			pack_c($urandom_range(3000), $urandom_range(3000), $urandom_range(3000)),
			RW'($urandom_range(6000)));
		return q;
	endfunction

	// stimulus
	initial begin
		query_t table_q [$];
		query_t q;
		logic [3*AW-1:0] ident [3];
		ident[0] = pack_a(16384, 0, 0);
		ident[1] = pack_a(0, 16384, 0);
		ident[2] = pack_a(0, 0, 16384);
		sh_center = '0; sh_half = '0; sh_radius = '0; sh_tol = '0;
		for (int i = 0; i < 3; i++) sh_axis[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset: everything zero, box and point at the origin touch
		q = '{1'b0, '0, 1};
		send(q, 0);
		q = '{1'b1, '0, 1};
		send(q, 0);
		drain();

		// unit box A of half size 1.0, radius about sqrt(3)
		write_box_a('0, ident[0], ident[1], ident[2], pack_c(1024, 1024, 1024),
			RW'(1774), '0);
		table_q = '{
			'{1'b0, build_box(pack_c(1500, 0, 0), ident[0], ident[1], ident[2],
				pack_c(1024, 1024, 1024), RW'(1774)), 1},
			'{1'b0, build_box(pack_c(3000, 0, 0), ident[0], ident[1], ident[2],
				pack_c(1024, 1024, 1024), RW'(1774)), 0},
			'{1'b0, build_box(pack_c(2048, 0, 0), ident[0], ident[1], ident[2],
				pack_c(1024, 1024, 1024), RW'(1774)), 1},
			'{1'b0, build_box(pack_c(2049, 0, 0), ident[0], ident[1], ident[2],
				pack_c(1024, 1024, 1024), RW'(1774)), 0},
			'{1'b1, build_box(pack_c(1024, -1024, 1024), '1, '1, '1, '1, '1), 1},
			'{1'b1, build_box(pack_c(1025, 0, 0), '0, '0, '0, '0, '0), 0},
			'{1'b1, build_box(pack_c(-524288, 524287, 0), '0, '0, '0, '0, '0), 0},
			// far corner diagonal, sphere rejects and faces separate
			'{1'b0, build_box(pack_c(1600, 1600, 1600), ident[0], ident[1], ident[2],
				pack_c(200, 200, 200), RW'(346)), -1},
			// rotated and degenerate B axes
			'{1'b0, build_box(pack_c(1800, 1800, 0), pack_a(11585, 11585, 0),
				pack_a(-11585, 11585, 0), ident[2], pack_c(1024, 1024, 1024),
				RW'(1774)), -1},
			'{1'b0, build_box(pack_c(500, 0, 0), '0, '0, '0, '0, '0), -1},
			'{1'b0, build_box(pack_c(1500, 0, 0), pack_a(-32768, 32767, -32768),
				pack_a(32767, 32767, 32767), pack_a(-32768, -32768, -32768),
				{3{CW'(1048575)}}, '1), -1},
			'{1'b0, build_box(pack_c(-524288, -524288, -524288), ident[0],
				ident[1], ident[2], '1, '1), -1},
			'{1'b0, build_box(pack_c(524287, 524287, 524287), ident[0],
				ident[1], ident[2], '0, '0), 0}
		};
		foreach (table_q[i]) send(table_q[i], 0);
		drain();

		// extremes of box A and maximum tolerance
		write_box_a(pack_c(-524288, 524287, -524288), pack_a(-32768, 32767, -32768),
			pack_a(32767, -32768, 32767), pack_a(-32768, -32768, -32768),
			'1, '1, '1);
		for (int i = 0; i < 6; i++) begin
			q = random_query();
			send(q, 0);
		end
		q = '{1'b0, '1, -1};
		q.data[IN_TDW-1:IN_BITS] = '0;
		send(q, 0);
		drain();

		// random phases with new box A each time
		for (int ph = 0; ph < 9; ph++) begin
			write_box_a(pack_c(near_coord(2000), near_coord(2000), near_coord(2000)),
				pack_a(near_coord(16384), near_coord(16384), near_coord(16384)),
				pack_a(near_coord(16384), near_coord(16384), near_coord(16384)),
				pack_a(near_coord(16384), near_coord(16384), near_coord(16384)),
				pack_c($urandom_range(4000), $urandom_range(4000), $urandom_range(4000)),
				(ph == 0) ? RW'(rand64()) : RW'($urandom_range(8000)),
				(ph % 3 == 0) ? TF'(0) : TF'($urandom()));
			// out of range index is ignored by the block
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= 3'd7;
			cfg_data <= '1;
			@(posedge clk);
			cfg_we <= 1'b0;
			if (ph == 4) hold_off = 1'b1;
			for (int n = 0; n < 200; n++) begin
				q = random_query();
				send(q, ph % 4 != 1);
			end
			s_tvalid <= 1'b0;
			drain();
		end

		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// result side: random stalls, plus one long hold-off
	initial begin
		int stall;
		int held;
		held = 0;
		forever begin
			@(posedge clk);
			if (hold_off && held == 0) begin
				m_tready <= 1'b0;
				repeat (60) @(posedge clk);
				held = 1;
			end
			stall = 0;
			if ($urandom_range(3) == 0)
				stall = ($urandom_range(15) == 0) ? $urandom_range(30, 8) : $urandom_range(2, 1);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall - 1) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// compare each result transfer with the oldest expected hit
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (hit_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result hit=%0d", m_tdata[0]);
			end else begin
				if (m_tdata[0] !== hit_queue[0] || m_tdata[OUT_TDW-1:1] !== '0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("hit mismatch: expected %0d got %0d",
							hit_queue[0], m_tdata);
				end
				void'(hit_queue.pop_front());
			end
		end
	end

	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
